### hw/rtl/vau_pkg.sv
package vau_pkg;

  localparam int FRAC_BITS_DEF = 16;

  typedef enum logic [3:0] {
    OP_ADD   = 4'd0,
    OP_SUB   = 4'd1,
    OP_MUL   = 4'd2,
    OP_DIV   = 4'd3,
    OP_SADD  = 4'd4,
    OP_SSUB  = 4'd5,
    OP_SMUL  = 4'd6,
    OP_SDIV  = 4'd7,
    OP_NEG   = 4'd8,
    OP_LERP  = 4'd9,
    OP_DOT   = 4'd10,
    OP_SQLEN = 4'd11,
    OP_LEN   = 4'd12,
    OP_NORM  = 4'd13,
    OP_EQ    = 4'd14
  } op_t;

endpackage

### hw/rtl/vec4_arith_unit_core.sv
// Four-component fixed-point vector ALU (signed Q(32-FRAC_BITS).FRAC_BITS).
//
// Input channel: in_valid / in_stall with opcode, vectors a_*, b_*, scalar_operand.
// Output channel: out_valid / out_stall with r_*, r_scalar, is_equal, arith_error.
// A transfer happens on a rising edge with valid high and stall low.
//
// Every opcode takes the same path through 71 register stages. One item is
// taken per cycle while the pipeline is not stalled. The depth
// is set by the square root (one root bit per stage, 33 stages) followed by
// the divider (one quotient bit per stage, 32 stages) that serves both
// divide opcodes and normalize.
//
// Reset clears all valid bits; nothing is in flight afterwards.
// When the receiver stalls while a result waits, the whole pipeline holds
// and in_stall goes high; no item is lost or repeated.
module vec4_arith_unit_core #(
  parameter int FRAC_BITS = vau_pkg::FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  opcode,
  input  logic [31:0] a_x,
  input  logic [31:0] a_y,
  input  logic [31:0] a_z,
  input  logic [31:0] a_w,
  input  logic [31:0] b_x,
  input  logic [31:0] b_y,
  input  logic [31:0] b_z,
  input  logic [31:0] b_w,
  input  logic [31:0] scalar_operand,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] r_x,
  output logic [31:0] r_y,
  output logic [31:0] r_z,
  output logic [31:0] r_w,
  output logic [31:0] r_scalar,
  output logic        is_equal,
  output logic        arith_error
);

  localparam int PW  = 66;                        // product
  localparam int SW  = 68;                        // sums
  localparam int NW  = 32 + FRAC_BITS;            // shifted dividend
  localparam int CW  = (NW > 64) ? NW : 64;       // divider remainder
  localparam int OW  = (NW > 65) ? NW : 65;       // overflow compare
  localparam int RDW = 66;                        // radicand
  localparam int RW  = 36;                        // sqrt remainder
  localparam int NSQ = 33;
  localparam int NDV = 32;

  localparam int ST_IN   = 0;
  localparam int ST_MUL  = 1;
  localparam int ST_LANE = 2;
  localparam int ST_SUM  = 3;
  localparam int ST_SQ0  = 4;
  localparam int ST_DSET = ST_SQ0 + NSQ;
  localparam int ST_DV0  = ST_DSET + 1;
  localparam int ST_OUT  = ST_DV0 + NDV;
  localparam int NST     = ST_OUT + 1;

  localparam logic [31:0] MAXV = 32'h7fff_ffff;
  localparam logic [31:0] MINV = 32'h8000_0000;

  typedef struct packed {
    logic [3:0]           op;
    logic [3:0][31:0]     a;
    logic [3:0][31:0]     b;
    logic [31:0]          s;
    logic [3:0][31:0]     r;
    logic [31:0]          rs;
    logic                 eq;
    logic                 err;
    logic [3:0]           an;
    logic [3:0]           neg;
    logic [3:0][31:0]     na;
    logic [3:0][31:0]     dy;
    logic [3:0][PW-1:0]   p;
    logic [1:0][SW-1:0]   ps;
    logic [RDW-1:0]       rad;
    logic [32:0]          root;
    logic [RW-1:0]        rem;
    logic [3:0][CW-1:0]   rq;
    logic [3:0][31:0]     q;
    logic [3:0][32:0]     d;
    logic [3:0]           ovf;
    logic [3:0]           dz;
  } item_t;

  function automatic logic signed [SW-1:0] sx(input logic [31:0] v);
    sx = {{(SW-32){v[31]}}, v};
  endfunction

  function automatic logic [31:0] sat(input logic signed [SW-1:0] v);
    if (v[SW-1:31] == {(SW-31){1'b0}} || v[SW-1:31] == {(SW-31){1'b1}})
      sat = v[31:0];
    else
      sat = v[SW-1] ? MINV : MAXV;
  endfunction

  item_t stg [NST];
  item_t nxt [NST];
  logic  vld [NST];
  logic  en;

  assign en       = !(vld[NST-1] && out_stall);
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NST; i++) vld[i] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
      for (int i = 1; i < NST; i++) vld[i] <= vld[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NST; i++) stg[i] <= nxt[i];
    end
  end

  // capture
  always_comb begin
    nxt[ST_IN]    = '0;
    nxt[ST_IN].op = opcode;
    nxt[ST_IN].a  = {a_w, a_z, a_y, a_x};
    nxt[ST_IN].b  = {b_w, b_z, b_y, b_x};
    nxt[ST_IN].s  = scalar_operand;
  end

  // multiplier, add/sub/neg, operand magnitudes
  always_comb begin
    item_t c;
    logic [31:0] y;
    logic signed [32:0] m1, m2;
    logic signed [PW-1:0] pr;
    logic is_s;
    c    = stg[ST_IN];
    is_s = (c.op == vau_pkg::OP_SADD) || (c.op == vau_pkg::OP_SSUB) ||
           (c.op == vau_pkg::OP_SMUL) || (c.op == vau_pkg::OP_SDIV);
    for (int i = 0; i < 4; i++) begin
      y  = is_s ? c.s : c.b[i];
      m1 = {c.a[i][31], c.a[i]};
      m2 = {y[31], y};
      if (c.op == vau_pkg::OP_LERP) begin
        m1 = {c.s[31], c.s};
        m2 = $signed({c.b[i][31], c.b[i]}) - $signed({c.a[i][31], c.a[i]});
      end else if (c.op == vau_pkg::OP_DOT) begin
        m2 = {c.b[i][31], c.b[i]};
      end else if (c.op == vau_pkg::OP_SQLEN || c.op == vau_pkg::OP_LEN ||
                   c.op == vau_pkg::OP_NORM) begin
        m2 = {c.a[i][31], c.a[i]};
      end
      pr       = m1 * m2;
      c.p[i]   = pr;
      c.an[i]  = c.a[i][31];
      c.na[i]  = c.a[i][31] ? (32'd0 - c.a[i]) : c.a[i];
      c.dy[i]  = y[31] ? (32'd0 - y) : y;
      c.neg[i] = (c.op == vau_pkg::OP_NORM) ? c.a[i][31] : (c.a[i][31] ^ y[31]);
      case (c.op)
        vau_pkg::OP_ADD, vau_pkg::OP_SADD: c.r[i] = sat(sx(c.a[i]) + sx(y));
        vau_pkg::OP_SUB, vau_pkg::OP_SSUB: c.r[i] = sat(sx(c.a[i]) - sx(y));
        vau_pkg::OP_NEG:                   c.r[i] = sat(-sx(c.a[i]));
        default:                           c.r[i] = '0;
      endcase
    end
    nxt[ST_MUL] = c;
  end

  // scale products, pairwise sums
  always_comb begin
    item_t c;
    logic signed [SW-1:0] pe [4];
    logic signed [SW-1:0] pl;
    c = stg[ST_MUL];
    for (int i = 0; i < 4; i++) begin
      pe[i] = {{(SW-PW){c.p[i][PW-1]}}, c.p[i]};
      pl    = pe[i] >>> FRAC_BITS;
      if (c.op == vau_pkg::OP_MUL || c.op == vau_pkg::OP_SMUL)
        c.r[i] = sat(pl);
      else if (c.op == vau_pkg::OP_LERP)
        c.r[i] = sat(pl + sx(c.a[i]));
    end
    c.ps[0] = pe[0] + pe[1];
    c.ps[1] = pe[2] + pe[3];
    nxt[ST_LANE] = c;
  end

  // total, dot result, radicand, compare
  always_comb begin
    item_t c;
    logic signed [SW-1:0] tot;
    c   = stg[ST_LANE];
    tot = $signed(c.ps[0]) + $signed(c.ps[1]);
    if (c.op == vau_pkg::OP_DOT || c.op == vau_pkg::OP_SQLEN)
      c.rs = sat(tot >>> FRAC_BITS);
    if (c.op == vau_pkg::OP_EQ)
      c.eq = (c.a == c.b);
    c.rad  = tot[RDW-1:0];   // sum of squares is nonnegative, at most 2^64
    c.root = '0;
    c.rem  = '0;
    nxt[ST_SUM] = c;
  end

  // square root, one root bit per stage
  for (genvar g = 0; g < NSQ; g++) begin : g_sqrt
    localparam int SI = ST_SQ0 + g;
    localparam int PB = 2 * (NSQ - 1 - g);
    always_comb begin
      item_t c;
      logic [RW-1:0] rn, trial;
      c     = stg[SI-1];
      rn    = {c.rem[RW-3:0], c.rad[PB+1 -: 2]};
      trial = RW'({c.root, 2'b01});
      if (rn >= trial) begin
        c.rem  = rn - trial;
        c.root = {c.root[31:0], 1'b1};
      end else begin
        c.rem  = rn;
        c.root = {c.root[31:0], 1'b0};
      end
      nxt[SI] = c;
    end
  end

  // divider setup: divisor, zero and overflow checks
  always_comb begin
    item_t c;
    logic [NW-1:0] nn;
    c = stg[ST_DSET-1];
    if (c.op == vau_pkg::OP_LEN)
      c.rs = (c.root[32] || c.root[31]) ? MAXV : c.root[31:0];
    for (int i = 0; i < 4; i++) begin
      nn       = {c.na[i], {FRAC_BITS{1'b0}}};
      c.d[i]   = (c.op == vau_pkg::OP_NORM) ? c.root : {1'b0, c.dy[i]};
      c.dz[i]  = (c.d[i] == 33'd0);
      c.ovf[i] = (OW'(nn) >= OW'({c.d[i], 32'd0}));
      c.rq[i]  = CW'(nn);
      c.q[i]   = '0;
    end
    nxt[ST_DSET] = c;
  end

  // restoring divide, one quotient bit per stage, MSB first
  for (genvar g = 0; g < NDV; g++) begin : g_div
    localparam int SI = ST_DV0 + g;
    localparam int K  = NDV - 1 - g;
    always_comb begin
      item_t c;
      logic [CW-1:0] sub;
      c = stg[SI-1];
      for (int i = 0; i < 4; i++) begin
        sub = CW'(c.d[i]) << K;
        if (c.rq[i] >= sub) begin
          c.rq[i]   = c.rq[i] - sub;
          c.q[i][K] = 1'b1;
        end
      end
      nxt[SI] = c;
    end
  end

  // sign, saturation and error flag for divide and normalize
  always_comb begin
    item_t c;
    logic is_div;
    c      = stg[ST_OUT-1];
    is_div = (c.op == vau_pkg::OP_DIV) || (c.op == vau_pkg::OP_SDIV) ||
             (c.op == vau_pkg::OP_NORM);
    if (is_div) begin
      c.err = |c.dz;
      for (int i = 0; i < 4; i++) begin
        if (c.dz[i])
          c.r[i] = c.an[i] ? MINV : MAXV;
        else if (c.neg[i])
          c.r[i] = (c.ovf[i] || (c.q[i][31] && c.q[i][30:0] != 31'd0)) ?
                   MINV : (32'd0 - c.q[i]);
        else
          c.r[i] = (c.ovf[i] || c.q[i][31]) ? MAXV : c.q[i];
      end
    end
    nxt[ST_OUT] = c;
  end

  assign out_valid   = vld[NST-1];
  assign r_x         = stg[NST-1].r[0];
  assign r_y         = stg[NST-1].r[1];
  assign r_z         = stg[NST-1].r[2];
  assign r_w         = stg[NST-1].r[3];
  assign r_scalar    = stg[NST-1].rs;
  assign is_equal    = stg[NST-1].eq;
  assign arith_error = stg[NST-1].err;

  a_in_enters: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> vld[0])
    else $error("accepted item did not enter the pipeline");

  a_flags_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(is_equal && arith_error))
    else $error("equal and error flags both set");

  a_scalar_only: assert property (@(posedge clk) disable iff (rst)
    out_valid && r_scalar != 32'd0 |->
      r_x == 32'd0 && r_y == 32'd0 && r_z == 32'd0 && r_w == 32'd0)
    else $error("scalar result with nonzero vector result");

  a_err_op: assert property (@(posedge clk) disable iff (rst)
    out_valid && arith_error |->
      stg[NST-1].op == vau_pkg::OP_DIV || stg[NST-1].op == vau_pkg::OP_SDIV ||
      stg[NST-1].op == vau_pkg::OP_NORM)
    else $error("error flag on an opcode that cannot raise it");

endmodule

### bench/tb_vec4_arith_unit_core.sv
`timescale 1ns / 1ps

module tb_vec4_arith_unit_core;

  localparam int FB = vau_pkg::FRAC_BITS_DEF;
  localparam longint FXMAX = 64'sd2147483647;
  localparam longint FXMIN = -64'sd2147483648;
  localparam int LATENCY = 71;
  localparam longint LIMIT = 400000;

  typedef struct packed {
    logic [31:0] x, y, z, w, s;
    logic eq, err;
  } vres_t;

  class vec_result_board;
    vres_t pending[$];
    int errors;

    function void note_input(vres_t r);
      pending.push_back(r);
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h want %h", what, got, want);
      errors++;
    endtask

    task check_result(vres_t got);
      vres_t e;
      if (pending.size() == 0) begin
        report("result with nothing pending", got.x, 32'h0);
        return;
      end
      e = pending.pop_front();
      if (got.x !== e.x) report("r_x", got.x, e.x);
      if (got.y !== e.y) report("r_y", got.y, e.y);
      if (got.z !== e.z) report("r_z", got.z, e.z);
      if (got.w !== e.w) report("r_w", got.w, e.w);
      if (got.s !== e.s) report("r_scalar", got.s, e.s);
      if (got.eq !== e.eq) report("is_equal", 32'(got.eq), 32'(e.eq));
      if (got.err !== e.err) report("arith_error", 32'(got.err), 32'(e.err));
    endtask
  endclass

  logic clk, rst;
  logic in_valid, in_stall, out_valid, out_stall;
  logic [3:0] opcode;
  logic [31:0] a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w, scalar_operand;
  logic [31:0] r_x, r_y, r_z, r_w, r_scalar;
  logic is_equal, arith_error;

  vec_result_board board = new();
  int send_idle_pct, recv_stall_pct;
  longint cycles;

  vec4_arith_unit_core u_dut (.*);

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  function automatic longint sat(longint v);
    if (v > FXMAX) return FXMAX;
    if (v < FXMIN) return FXMIN;
    return v;
  endfunction

  // arithmetic shift floors; the 128-bit width keeps the products exact
  function automatic longint fmul(longint a, longint b);
    logic signed [127:0] p;
    p = 128'(a) * 128'(b);
    p = p >>> FB;
    if (p > FXMAX) return FXMAX;
    if (p < FXMIN) return FXMIN;
    return longint'(p);
  endfunction

  function automatic longint fdiv(longint a, longint b, inout bit err);
    logic [127:0] na, db, q;
    if (b == 0) begin
      err = 1;
      return a < 0 ? FXMIN : FXMAX;
    end
    na = a < 0 ? -a : a;
    db = b < 0 ? -b : b;
    q = (na << FB) / db;
    if ((a < 0) != (b < 0)) return sat(-longint'(q));
    return sat(longint'(q));
  endfunction

  function automatic longint root_len(longint v[4]);
    logic [127:0] s, r, c;
    s = 0;
    r = 0;
    for (int i = 0; i < 4; i++) s += 128'(v[i] * v[i]);
    for (int bt = 33; bt >= 0; bt--) begin
      c = r | (128'd1 << bt);
      if (c * c <= s) r = c;
    end
    return longint'(r);
  endfunction

  function automatic longint dot4(longint a[4], longint b[4]);
    logic signed [127:0] acc;
    acc = 0;
    for (int i = 0; i < 4; i++) acc += 128'(a[i]) * 128'(b[i]);
    acc = acc >>> FB;
    if (acc > FXMAX) return FXMAX;
    if (acc < FXMIN) return FXMIN;
    return longint'(acc);
  endfunction

  // unsaturated floor(s*d / 2^FB) for lerp
  function automatic longint lerp_term(longint s, longint d);
    logic signed [127:0] p;
    p = (128'(s) * 128'(d)) >>> FB;
    return longint'(p);
  endfunction

  function automatic vres_t vec_alu(logic [3:0] op,
      logic [31:0] av[4], logic [31:0] bv[4], logic [31:0] sv);
    vres_t res;
    longint a[4], b[4], r[4], s, y, len;
    bit err;
    res = '0;
    err = 0;
    s = longint'(signed'(sv));
    for (int i = 0; i < 4; i++) begin
      a[i] = longint'(signed'(av[i]));
      b[i] = longint'(signed'(bv[i]));
      r[i] = 0;
    end
    case (op)
      vau_pkg::OP_ADD, vau_pkg::OP_SUB, vau_pkg::OP_MUL, vau_pkg::OP_DIV,
      vau_pkg::OP_SADD, vau_pkg::OP_SSUB, vau_pkg::OP_SMUL, vau_pkg::OP_SDIV:
        for (int i = 0; i < 4; i++) begin
          y = op >= vau_pkg::OP_SADD ? s : b[i];
          case (op[1:0])
            2'd0: r[i] = sat(a[i] + y);
            2'd1: r[i] = sat(a[i] - y);
            2'd2: r[i] = fmul(a[i], y);
            default: r[i] = fdiv(a[i], y, err);
          endcase
        end
      vau_pkg::OP_NEG: for (int i = 0; i < 4; i++) r[i] = sat(-a[i]);
      vau_pkg::OP_LERP:
        for (int i = 0; i < 4; i++) r[i] = sat(a[i] + lerp_term(s, b[i] - a[i]));
      vau_pkg::OP_DOT: res.s = 32'(dot4(a, b));
      vau_pkg::OP_SQLEN: res.s = 32'(dot4(a, a));
      vau_pkg::OP_LEN: res.s = 32'(sat(root_len(a)));
      vau_pkg::OP_NORM: begin
        len = root_len(a);
        if (len == 0) begin
          err = 1;
          for (int i = 0; i < 4; i++) r[i] = FXMAX;
        end else
          for (int i = 0; i < 4; i++) r[i] = fdiv(a[i], len, err);
      end
      vau_pkg::OP_EQ:
        res.eq = (a[0] == b[0]) && (a[1] == b[1]) && (a[2] == b[2]) && (a[3] == b[3]);
      default: ;
    endcase
    res.x = 32'(r[0]);
    res.y = 32'(r[1]);
    res.z = 32'(r[2]);
    res.w = 32'(r[3]);
    res.err = err;
    return res;
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 9))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'h0;
      3: return $urandom_range(0, 1) ? 32'h00010000 : 32'hffff0000;
      4, 5: return 32'($urandom_range(0, 32'h3ffff)) - 32'h20000;
      default: return $urandom();
    endcase
  endfunction

  task automatic send(logic [3:0] op, logic [31:0] av[4], logic [31:0] bv[4],
      logic [31:0] sv);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    opcode <= op;
    {a_x, a_y, a_z, a_w} <= {av[0], av[1], av[2], av[3]};
    {b_x, b_y, b_z, b_w} <= {bv[0], bv[1], bv[2], bv[3]};
    scalar_operand <= sv;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_input(vec_alu(op, av, bv, sv));
  endtask

  task automatic send_random(int n);
    logic [31:0] av[4], bv[4];
    logic [3:0] op;
    for (int k = 0; k < n; k++) begin
      op = 4'($urandom_range(0, 15));
      for (int i = 0; i < 4; i++) begin
        av[i] = rand_word();
        bv[i] = $urandom_range(0, 7) == 0 ? av[i] : rand_word();
      end
      send(op, av, bv, rand_word());
    end
    in_valid <= 0;
  endtask

  always @(posedge clk) begin
    if (rst) out_stall <= 0;
    else out_stall <= $urandom_range(0, 99) < recv_stall_pct;
    if (!rst && out_valid && !out_stall)
      board.check_result({r_x, r_y, r_z, r_w, r_scalar, is_equal, arith_error});
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    logic [31:0] z4[4], mx[4], mn[4], one[4], mix[4];
    cycles = 0;
    rst = 1;
    in_valid = 0;
    opcode = '0;
    {a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w, scalar_operand} = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    z4 = '{4{32'h0}};
    mx = '{4{32'h7fffffff}};
    mn = '{4{32'h80000000}};
    one = '{4{32'h00010000}};
    mix = '{32'h7fffffff, 32'h80000000, 32'hffffffff, 32'h00000001};
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // directed: each opcode, extremes, divide by zero, zero normalize
    for (int op = 0; op < 16; op++) send(4'(op), mix, mn, 32'h80000000);
    send(vau_pkg::OP_DIV, mix, z4, 32'h0);
    send(vau_pkg::OP_SDIV, mn, mx, 32'h0);
    send(vau_pkg::OP_NORM, z4, z4, 32'h0);
    send(vau_pkg::OP_NORM, mn, z4, 32'h0);
    send(vau_pkg::OP_LEN, mn, z4, 32'h0);
    send(vau_pkg::OP_SQLEN, mx, z4, 32'h0);
    send(vau_pkg::OP_EQ, one, one, 32'h0);
    send(vau_pkg::OP_LERP, mn, mx, 32'h7fffffff);
    send(vau_pkg::OP_MUL, mx, mx, 32'h0);
    in_valid <= 0;
    send_random(140);
    send_idle_pct = 67;
    send_random(140);
    send_idle_pct = 0;
    recv_stall_pct = 67;
    send_random(140);
    send_idle_pct = 33;
    recv_stall_pct = 33;
    send_random(130);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
